[design/huffman_tree_walk_decoder_core_defines.svh]
// Assertion macros shared by the decoder modules.
`ifndef HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HTWD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("htwd assertion failed");

// Next-cycle implication, disabled during reset.
`define HTWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("htwd assertion failed");

`endif

[design/htwd_pkg.sv]
// Types and constants of the tree walk decoder.
package htwd_pkg;

  localparam int IDX_W          = 9;
  localparam int SYM_W          = 8;
  localparam int BYTE_W         = 8;
  localparam int BIT_CNT_W      = 3;
  localparam int TOP_BIT        = 7;
  localparam int NODE_COUNT_DEF = 512;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  // walker -> node store
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    node_t            wr_node;
    logic [IDX_W-1:0] rd_idx;
  } store_req_t;

  // walker -> output register
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } push_t;

endpackage

[design/htwd_node_store.sv]
// Node store: one write port, one registered read port, zero node out of range.
module htwd_node_store #(
  parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
  input  logic                 clk,
  input  htwd_pkg::store_req_t req,
  output htwd_pkg::node_t      rd_node
);

  localparam int AW = $clog2(NODE_COUNT);

  htwd_pkg::node_t mem [NODE_COUNT];
  htwd_pkg::node_t rd_q;
  logic            rd_zero;

  logic wr_ok;
  logic rd_ok;

  assign wr_ok = (32'(req.wr_idx) < NODE_COUNT);
  assign rd_ok = (32'(req.rd_idx) < NODE_COUNT);

  always_ff @(posedge clk) begin
    if (req.wr_en && wr_ok) begin
      mem[AW'(req.wr_idx)] <= req.wr_node;
    end
    rd_q    <= mem[AW'(req.rd_idx)];
    rd_zero <= !rd_ok;
  end

  // indices past the store read as an inner node with both children 0
  assign rd_node = rd_zero ? '0 : rd_q;

endmodule

[design/htwd_walker.sv]
// Bit sequencer: steps the tree one node read per bit and holds the pending symbol.
`include "huffman_tree_walk_decoder_core_defines.svh"

module htwd_walker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         req_type,
  input  logic [htwd_pkg::IDX_W-1:0]   node_index,
  input  logic                         node_is_leaf,
  input  logic [htwd_pkg::SYM_W-1:0]   node_symbol,
  input  logic [htwd_pkg::IDX_W-1:0]   left_child,
  input  logic [htwd_pkg::IDX_W-1:0]   right_child,
  input  logic [htwd_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         cfg_wr_en,
  input  logic [htwd_pkg::IDX_W-1:0]   cfg_wr_data,
  output htwd_pkg::store_req_t         store_req,
  input  htwd_pkg::node_t              rd_node,
  output htwd_pkg::push_t              push,
  input  logic                         push_ready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CUR   = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]                        state, state_next;
  logic [htwd_pkg::IDX_W-1:0]        root, root_next;
  logic [htwd_pkg::IDX_W-1:0]        walk_pos, walk_pos_next;
  logic [htwd_pkg::IDX_W-1:0]        child, child_next;
  logic [htwd_pkg::BYTE_W-1:0]       bits, bits_next;
  logic [htwd_pkg::BIT_CNT_W-1:0]    bit_cnt, bit_cnt_next;
  logic                              pend_valid, pend_valid_next;
  logic [htwd_pkg::SYM_W-1:0]        pend_sym, pend_sym_next;

  logic                              last_bit;
  logic [htwd_pkg::IDX_W-1:0]        pick_now;
  logic [htwd_pkg::IDX_W-1:0]        pick_after;

  assign last_bit   = (bit_cnt == htwd_pkg::BIT_CNT_W'(htwd_pkg::TOP_BIT));
  // child of the node on the read port, for this bit and for the bit after it
  assign pick_now   = bits[htwd_pkg::BYTE_W-1] ? rd_node.right : rd_node.left;
  assign pick_after = bits[htwd_pkg::BYTE_W-2] ? rd_node.right : rd_node.left;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    root_next       = root;
    walk_pos_next   = walk_pos;
    child_next      = child;
    bits_next       = bits;
    bit_cnt_next    = bit_cnt;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;

    store_req.wr_en   = 1'b0;
    store_req.wr_idx  = node_index;
    store_req.wr_node = '{leaf: node_is_leaf, sym: node_symbol,
                          left: left_child, right: right_child};
    store_req.rd_idx  = walk_pos;

    push.valid  = 1'b0;
    push.symbol = pend_sym;
    push.last   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (cfg_wr_en) begin
          root_next        = cfg_wr_data;
          walk_pos_next    = cfg_wr_data;
          store_req.rd_idx = cfg_wr_data;
        end
        if (req_valid) begin
          if (req_type == htwd_pkg::REQ_LOAD) begin
            store_req.wr_en = 1'b1;
          end else begin
            bits_next    = data_byte;
            bit_cnt_next = '0;
            state_next   = S_CUR;
          end
        end
      end
      S_CUR: begin
        // read port holds the node at the walk position
        store_req.rd_idx = pick_now;
        child_next       = pick_now;
        state_next       = S_STEP;
      end
      S_STEP: begin
        // read port holds the child chosen by the current bit
        store_req.rd_idx = child;
        if (rd_node.leaf) begin
          if (!pend_valid || push_ready) begin
            push.valid      = pend_valid;
            pend_valid_next = 1'b1;
            pend_sym_next   = rd_node.sym;
            walk_pos_next   = root;
            bits_next       = bits << 1;
            bit_cnt_next    = bit_cnt + 1'b1;
            store_req.rd_idx = root;
            state_next      = last_bit ? S_FLUSH : S_CUR;
          end
        end else begin
          walk_pos_next    = child;
          bits_next        = bits << 1;
          bit_cnt_next     = bit_cnt + 1'b1;
          store_req.rd_idx = pick_after;
          child_next       = pick_after;
          state_next       = last_bit ? S_FLUSH : S_STEP;
        end
      end
      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (push_ready) begin
          push.valid      = 1'b1;
          push.last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      root       <= '0;
      walk_pos   <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      root       <= root_next;
      walk_pos   <= walk_pos_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    child    <= child_next;
    bits     <= bits_next;
    bit_cnt  <= bit_cnt_next;
    pend_sym <= pend_sym_next;
  end

  `HTWD_ASSERT_NOW(a_push_in_walk, clk, rst, push.valid, (state == S_STEP) || (state == S_FLUSH))
  `HTWD_ASSERT_NOW(a_idle_no_pend, clk, rst, state == S_IDLE, !pend_valid)
  `HTWD_ASSERT_NEXT(a_flush_after_step, clk, rst, (state == S_IDLE) || (state == S_CUR),
                    state != S_FLUSH)

endmodule

[design/htwd_out_reg.sv]
// Output word register between the walker and the symbol channel.
`include "huffman_tree_walk_decoder_core_defines.svh"

module htwd_out_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  htwd_pkg::push_t            push,
  output logic                       push_ready,
  output logic                       sym_valid,
  input  logic                       sym_stall,
  output logic [htwd_pkg::SYM_W-1:0] symbol,
  output logic                       last
);

  assign push_ready = !sym_valid || !sym_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_valid <= 1'b0;
    end else if (push.valid && push_ready) begin
      sym_valid <= 1'b1;
    end else if (!sym_stall) begin
      sym_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid && push_ready) begin
      symbol <= push.symbol;
      last   <= push.last;
    end
  end

  `HTWD_ASSERT_NOW(a_push_when_ready, clk, rst, push.valid, push_ready)
  `HTWD_ASSERT_NEXT(a_push_lands, clk, rst, push.valid, sym_valid)
  `HTWD_ASSERT_NEXT(a_push_last_lands, clk, rst, push.valid && push.last, last)

endmodule

[design/huffman_tree_walk_decoder_core.sv]
// Top level of the bit-serial Huffman tree walk decoder.
//
// Request channel (req_valid / req_stall): one word per request. req_type
// selects a node load (writes node_index with leaf flag, symbol and both
// child indices) or a decode of data_byte, taken MSB first.
// Symbol channel (sym_valid / sym_stall): one word per decoded symbol;
// last marks the final symbol of a data byte. A byte that completes no
// code gives no word.
// Config: cfg_wr_en / cfg_wr_data write the root index and move the walk
// to it; write only while the block is idle.
// Timing: a load is written at the accept edge and leaves req_stall low.
// A decode takes one node read per bit through the single store read port,
// plus one read to fetch the walk node at byte start and after each leaf
// that is not on the last bit, plus a flush step: req_stall stays high
// from the accept until the walker is idle again, so the next decode is
// taken only after the byte's last word has gone to the output register.
// The walk position carries from byte to byte.
// Reset clears root and walk position to 0 and empties the output word;
// the node store is not cleared. A stalled symbol word holds, and the
// walker waits on the next leaf until the output register frees up.
module huffman_tree_walk_decoder_core #(
  parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        req_type,
  input  logic [htwd_pkg::IDX_W-1:0]  node_index,
  input  logic                        node_is_leaf,
  input  logic [htwd_pkg::SYM_W-1:0]  node_symbol,
  input  logic [htwd_pkg::IDX_W-1:0]  left_child,
  input  logic [htwd_pkg::IDX_W-1:0]  right_child,
  input  logic [htwd_pkg::BYTE_W-1:0] data_byte,
  // root index register
  input  logic                        cfg_wr_en,
  input  logic [htwd_pkg::IDX_W-1:0]  cfg_wr_data,
  // symbol channel
  output logic                        sym_valid,
  input  logic                        sym_stall,
  output logic [htwd_pkg::SYM_W-1:0]  symbol,
  output logic                        last
);

  htwd_pkg::store_req_t store_req;
  htwd_pkg::node_t      rd_node;
  htwd_pkg::push_t      push;
  logic                 push_ready;

  // NODE_COUNT x 27 store (512 by default), read data registered; one read per cycle drives the walk
  htwd_node_store #(
    .NODE_COUNT (NODE_COUNT)
  ) u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_node (rd_node)
  );

  // sequencer: one bit per store read, holds back the newest symbol so the
  // last flag can be set once the byte runs out
  htwd_walker u_walker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .node_index   (node_index),
    .node_is_leaf (node_is_leaf),
    .node_symbol  (node_symbol),
    .left_child   (left_child),
    .right_child  (right_child),
    .data_byte    (data_byte),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .store_req    (store_req),
    .rd_node      (rd_node),
    .push         (push),
    .push_ready   (push_ready)
  );

  // output word register, refilled in the cycle it drains
  htwd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .sym_valid  (sym_valid),
    .sym_stall  (sym_stall),
    .symbol     (symbol),
    .last       (last)
  );

endmodule

[tb/huffman_tree_walk_decoder_checker.sv]
// Scoreboard for the tree walk decoder: tracks tree, root and walk, checks symbol words.
`timescale 1ns / 100ps

module huffman_tree_walk_decoder_checker #(
  parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  logic                        req_type,
  input  logic [htwd_pkg::IDX_W-1:0]  node_index,
  input  logic                        node_is_leaf,
  input  logic [htwd_pkg::SYM_W-1:0]  node_symbol,
  input  logic [htwd_pkg::IDX_W-1:0]  left_child,
  input  logic [htwd_pkg::IDX_W-1:0]  right_child,
  input  logic [htwd_pkg::BYTE_W-1:0] data_byte,
  input  logic                        cfg_wr_en,
  input  logic [htwd_pkg::IDX_W-1:0]  cfg_wr_data,
  input  logic                        sym_valid,
  input  logic                        sym_stall,
  input  logic [htwd_pkg::SYM_W-1:0]  symbol,
  input  logic                        last,
  output int                          fail_count,
  output int                          pending_count
);

  typedef struct packed {
    logic [htwd_pkg::SYM_W-1:0] sym;
    logic                       is_last;
  } symbol_word_t;

  htwd_pkg::node_t            tree_nodes [NODE_COUNT];
  logic [htwd_pkg::IDX_W-1:0] root_reg;
  logic [htwd_pkg::IDX_W-1:0] walk_reg;
  symbol_word_t               expected_symbols [$];
  int                         mismatches;

  initial begin
    for (int i = 0; i < NODE_COUNT; i++) tree_nodes[i] = '0;
    root_reg      = '0;
    walk_reg      = '0;
    mismatches    = 0;
    fail_count    = 0;
    pending_count = 0;
  end

  // out-of-range reads see an inner node with both children at 0
  function automatic htwd_pkg::node_t read_node(input logic [htwd_pkg::IDX_W-1:0] idx);
    if (idx < NODE_COUNT) return tree_nodes[idx];
    return '0;
  endfunction

  // one bit per step, MSB first; each leaf reached yields a symbol word
  task automatic walk_byte(input logic [htwd_pkg::BYTE_W-1:0] byte_in);
    htwd_pkg::node_t            here;
    htwd_pkg::node_t            next_node;
    logic [htwd_pkg::IDX_W-1:0] next_idx;
    logic [htwd_pkg::SYM_W-1:0] found [htwd_pkg::BYTE_W];
    int                         n;
    n = 0;
    for (int b = htwd_pkg::TOP_BIT; b >= 0; b--) begin
      here      = read_node(walk_reg);
      next_idx  = byte_in[b] ? here.right : here.left;
      next_node = read_node(next_idx);
      if (next_node.leaf) begin
        found[n] = next_node.sym;
        n++;
        walk_reg = root_reg;
      end else begin
        walk_reg = next_idx;
      end
    end
    for (int i = 0; i < n; i++) expected_symbols.push_back({found[i], i == n - 1});
  endtask

  always @(posedge clk) begin
    symbol_word_t want;
    if (rst) begin
      root_reg = '0;
      walk_reg = '0;
      expected_symbols.delete();
    end else begin
      if (cfg_wr_en) begin
        root_reg = cfg_wr_data;
        walk_reg = cfg_wr_data;
      end
      if (req_valid && !req_stall) begin
        if (req_type == htwd_pkg::REQ_LOAD) begin
          if (node_index < NODE_COUNT)
            tree_nodes[node_index] = '{leaf: node_is_leaf, sym: node_symbol,
                                       left: left_child, right: right_child};
        end else begin
          walk_byte(data_byte);
        end
      end
      if (sym_valid && !sym_stall) begin
        if (expected_symbols.size() == 0) begin
          $error("symbol word with nothing expected: symbol %0h last %0b", symbol, last);
          mismatches++;
        end else begin
          want = expected_symbols.pop_front();
          if (symbol !== want.sym) begin
            $error("symbol mismatch: expected %0h, actual %0h", want.sym, symbol);
            mismatches++;
          end
          if (last !== want.is_last) begin
            $error("last mismatch: expected %0b, actual %0b", want.is_last, last);
            mismatches++;
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_symbols.size();
  end

endmodule

[tb/tb_huffman_tree_walk_decoder_core.sv]
// Testbench top for the tree walk decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_huffman_tree_walk_decoder_core;

  localparam int IDX_W  = htwd_pkg::IDX_W;
  localparam int SYM_W  = htwd_pkg::SYM_W;
  localparam int BYTE_W = htwd_pkg::BYTE_W;

  // Generous ceiling: ~110 to 160 words, worst case 8 symbols each behind
  // the longest random stalls, plus sender gaps, config settling and the long hold.
  localparam int CYCLE_LIMIT = 200000;
  // Long enough to outlast a decode that produces no symbol.
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TARGET_WORDS = 110;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic              req_type = htwd_pkg::REQ_LOAD;
  logic [IDX_W-1:0]  node_index = '0;
  logic              node_is_leaf = 1'b0;
  logic [SYM_W-1:0]  node_symbol = '0;
  logic [IDX_W-1:0]  left_child = '0;
  logic [IDX_W-1:0]  right_child = '0;
  logic [BYTE_W-1:0] data_byte = '0;
  logic              cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]  cfg_wr_data = '0;
  logic              sym_valid;
  logic              sym_stall = 1'b0;
  logic [SYM_W-1:0]  symbol;
  logic              last;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int words_sent = 0;

  // Every node ever loaded. Children are only ever drawn from this list, so
  // no walk can reach a store entry that was never written.
  logic [IDX_W-1:0] written_nodes [$];

  // Pressure controls, each written only by the stimulus process.
  logic long_hold_go = 1'b0;
  logic no_idle = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  huffman_tree_walk_decoder_core u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .node_index   (node_index),
    .node_is_leaf (node_is_leaf),
    .node_symbol  (node_symbol),
    .left_child   (left_child),
    .right_child  (right_child),
    .data_byte    (data_byte),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .sym_valid    (sym_valid),
    .sym_stall    (sym_stall),
    .symbol       (symbol),
    .last         (last)
  );

  huffman_tree_walk_decoder_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .node_index    (node_index),
    .node_is_leaf  (node_is_leaf),
    .node_symbol   (node_symbol),
    .left_child    (left_child),
    .right_child   (right_child),
    .data_byte     (data_byte),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .sym_valid     (sym_valid),
    .sym_stall     (sym_stall),
    .symbol        (symbol),
    .last          (last),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Symbol side back-pressure. Short random stalls between short flowing
  // runs, now and then a long one; a single long hold when asked for, which
  // lets decodes pile up until the block stalls its request side.
  int  stall_left = 0;
  int  flow_left = 0;
  int  hold_left = 0;
  logic long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      sym_stall <= 1'b0;
    end else if (hold_left != 0) begin
      sym_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_hold_go && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD_CYCLES;
      sym_stall      <= 1'b1;
    end else if (no_idle) begin
      sym_stall <= 1'b0;
    end else if (stall_left != 0) begin
      sym_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (flow_left != 0) begin
      sym_stall <= 1'b0;
      flow_left <= flow_left - 1;
    end else begin
      sym_stall  <= 1'b0;
      flow_left  <= $urandom_range(0, 6);
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one request word after a random gap and hold it until taken.
  // Valid only drops in a gap, so a back-to-back word never toggles it.
  task automatic offer_word(input logic kind, input logic [IDX_W-1:0] idx,
                            input logic leaf, input logic [SYM_W-1:0] sym,
                            input logic [IDX_W-1:0] lc, input logic [IDX_W-1:0] rc,
                            input logic [BYTE_W-1:0] byte_in);
    int gap;
    gap = 0;
    if (!no_idle) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3:       gap = $urandom_range(8, 30);
        default: gap = 0;
      endcase
    end
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_type     <= kind;
    node_index   <= idx;
    node_is_leaf <= leaf;
    node_symbol  <= sym;
    left_child   <= lc;
    right_child  <= rc;
    data_byte    <= byte_in;
    req_valid    <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    words_sent++;
  endtask

  // Load word; data_byte is don't-care and gets noise.
  task automatic send_load(input logic [IDX_W-1:0] idx, input logic leaf,
                           input logic [SYM_W-1:0] sym, input logic [IDX_W-1:0] lc,
                           input logic [IDX_W-1:0] rc);
    offer_word(htwd_pkg::REQ_LOAD, idx, leaf, sym, lc, rc, BYTE_W'($urandom));
    written_nodes.push_back(idx);
  endtask

  // Decode word; all node fields are don't-care and get noise.
  task automatic send_decode(input logic [BYTE_W-1:0] byte_in);
    offer_word(htwd_pkg::REQ_DECODE, IDX_W'($urandom), 1'($urandom), SYM_W'($urandom),
               IDX_W'($urandom), IDX_W'($urandom), byte_in);
  endtask

  function automatic logic [IDX_W-1:0] any_written();
    return written_nodes[$urandom_range(0, written_nodes.size() - 1)];
  endfunction

  // Root writes only go in while the block is idle: drop valid, wait for
  // every expected symbol, then cover a decode that may yield nothing.
  task automatic write_root(input logic [IDX_W-1:0] root);
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_data <= root;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int               seq;
    int               trees;
    int               leaves;
    int               p;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] pool [$];
    bit               taken [htwd_pkg::NODE_COUNT_DEF];
    bit               quiet_run;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed tree rooted at 0 (the reset root):
    //   0 -> node 1 (leaf 00), 10 -> node 511 (leaf FF), 11 -> node 3 (leaf 5A)
    // Leaves point at themselves so a leaf used as root stays in known nodes.
    send_load(9'd1,   1'b1, 8'h00, 9'd1,   9'd1);
    send_load(9'd511, 1'b1, 8'hFF, 9'd511, 9'd511);
    send_load(9'd3,   1'b1, 8'h5A, 9'd3,   9'd3);
    send_load(9'd2,   1'b0, 8'hC3, 9'd511, 9'd3);
    send_load(9'd0,   1'b0, 8'h00, 9'd1,   9'd2);
    // node 5 loops on 0 bits: as root it can swallow whole bytes
    send_load(9'd5,   1'b0, 8'h81, 9'd5,   9'd2);

    send_decode(8'h00);   // eight symbols from one byte
    send_decode(8'hFF);   // four two-bit codes
    send_decode(8'hA5);   // ends mid-code, walk sits on node 2
    send_decode(8'h80);   // first bit finishes the carried code
    send_decode(8'h01);   // leaves the walk on node 2 again

    // Root write pulls the walk back to the root mid-code.
    write_root(9'd0);
    send_decode(8'h7F);

    // Bytes that finish no code, then a code carried across two bytes.
    write_root(9'd5);
    send_decode(8'h00);
    send_decode(8'h01);
    send_decode(8'h80);

    // Leaf as root: every bit steps onto the leaf itself.
    write_root(9'd511);
    send_decode(8'h3C);

    write_root(9'd0);

    // Random part. Mostly fresh well-formed trees at scattered indices,
    // rooted by a register write, then random bytes; the rest is noise:
    // stray node rewrites and decodes over whatever tree is in place.
    seq       = 0;
    trees     = 0;
    quiet_run = 1'b0;
    while (words_sent < TARGET_WORDS) begin
      if (seq < 4 || $urandom_range(0, 3) != 0) begin
        leaves = (trees % 5 == 4) ? $urandom_range(12, 20) : $urandom_range(2, 6);
        pool.delete();
        foreach (taken[i]) taken[i] = 1'b0;
        for (int i = 0; i < leaves; i++) begin
          do idx = IDX_W'($urandom); while (taken[idx]);
          taken[idx] = 1'b1;
          send_load(idx, 1'b1, SYM_W'($urandom),
                    $urandom_range(0, 1) ? idx : any_written(), any_written());
          pool.push_back(idx);
        end
        // merge two random subtrees under a new inner node until one is left
        while (pool.size() > 1) begin
          p = $urandom_range(0, pool.size() - 1);
          a = pool[p];
          pool.delete(p);
          p = $urandom_range(0, pool.size() - 1);
          b = pool[p];
          pool.delete(p);
          do idx = IDX_W'($urandom); while (taken[idx]);
          taken[idx] = 1'b1;
          send_load(idx, 1'b0, SYM_W'($urandom), a, b);
          pool.push_back(idx);
        end
        write_root(pool[0]);
        // second tree: receiver holds off while decodes keep coming
        if (trees == 1) long_hold_go <= 1'b1;
        // fourth tree: neither side idles
        if (trees == 3) begin
          no_idle   <= 1'b1;
          quiet_run = 1'b1;
        end
        repeat ($urandom_range(3, 10)) send_decode(BYTE_W'($urandom));
        if (quiet_run) begin
          no_idle   <= 1'b0;
          quiet_run = 1'b0;
        end
        trees++;
      end else begin
        repeat ($urandom_range(3, 8)) begin
          if ($urandom_range(0, 2) == 0)
            send_load(IDX_W'($urandom), 1'($urandom), SYM_W'($urandom),
                      any_written(), any_written());
          else
            send_decode(BYTE_W'($urandom));
        end
      end
      seq++;
    end

    // Drain, then allow for a trailing decode that produces nothing.
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
